// File: sv/integer_field_formatter_core_assert.svh
// Assertion macros for the integer field formatter
`ifndef INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH
// implication checked on every clock unless in reset
`define IFF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define IFF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/iff_pkg.sv
// Package: types, constants and character helper for the integer field formatter
`default_nettype none
package iff_pkg;
    localparam int DIGIT_SLOTS = 24;
    localparam int MAX_FIELD   = 63;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] RADIX_OCT     = 2'd0;
    localparam logic [1:0] RADIX_DEC     = 2'd1;
    localparam logic [1:0] RADIX_HEX     = 2'd2;
    localparam logic [1:0] RADIX_HEX_ALT = 2'd3;

    // decimal digit steps: low and high estimate, then the fix-up
    localparam logic [1:0] DPH_LO  = 2'd0;
    localparam logic [1:0] DPH_HI  = 2'd1;
    localparam logic [1:0] DPH_FIX = 2'd2;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CONV,
        BS_PADL,
        BS_SIGN,
        BS_PFX0,
        BS_PFXX,
        BS_ZERO,
        BS_DIGS
    } bs_t;

    // classified word passed from front to back
    typedef struct packed {
        logic [63:0] mag;
        logic [1:0]  radix;
        logic        lower;
        logic        left;
        logic        zp;
        logic [7:0]  sign_ch;
        logic        pfx0;
        logic        pfxx;
        logic [5:0]  width;
        logic [5:0]  prec;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'd0, d};
        else
            r = (lower ? 8'h61 : 8'h41) + {4'd0, d} - 8'd10;
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/integer_field_formatter_core.sv
// Integer field formatter: printf-style integer to ASCII character stream
// The back-end sequencer takes one queued item at a time and returns to idle after each;
// the receiver cannot stall. A two-word queue lets the front accept while the back emits.
// Asynchronous active-low reset empties the queue and idles the sequencer.
`default_nettype none
module integer_field_formatter_core
    import iff_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] value,
    input  wire logic [1:0]  value_size,
    input  wire logic        is_signed,
    input  wire logic [1:0]  radix_sel,
    input  wire logic        lower_case,
    input  wire logic        left_justify,
    input  wire logic        show_plus,
    input  wire logic        show_space,
    input  wire logic        alt_prefix,
    input  wire logic        zero_pad,
    input  wire logic [5:0]  min_width,
    input  wire logic [5:0]  min_digits,
    output logic             strobe,
    output logic [7:0]       ch,
    output logic             last
);
    job_t fjob, qjob;
    logic qempty, qfull, pop;

    iff_front u_front (
        .value(value), .value_size(value_size), .is_signed(is_signed),
        .radix_sel(radix_sel), .lower_case(lower_case), .left_justify(left_justify),
        .show_plus(show_plus), .show_space(show_space), .alt_prefix(alt_prefix),
        .zero_pad(zero_pad), .min_width(min_width), .min_digits(min_digits),
        .job(fjob)
    );

    iff_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(start && !qfull), .din(fjob),
        .pop(pop), .dout(qjob), .empty(qempty), .full(qfull)
    );

    iff_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(qempty), .q_job(qjob), .pop(pop),
        .strobe(strobe), .ch(ch), .last(last)
    );

    assign busy = qfull;
endmodule
`default_nettype wire

// File: sv/iff_front.sv
// Front end: size/sign handling and classification into a job word
`default_nettype none
module iff_front
    import iff_pkg::*;
(
    input  wire logic [63:0] value,
    input  wire logic [1:0]  value_size,
    input  wire logic        is_signed,
    input  wire logic [1:0]  radix_sel,
    input  wire logic        lower_case,
    input  wire logic        left_justify,
    input  wire logic        show_plus,
    input  wire logic        show_space,
    input  wire logic        alt_prefix,
    input  wire logic        zero_pad,
    input  wire logic [5:0]  min_width,
    input  wire logic [5:0]  min_digits,
    output job_t             job
);
    logic [63:0] v;
    logic        neg;
    logic        hex;
    always_comb
    begin
        case (value_size)
            2'd0: v = is_signed ? {{56{value[7]}}, value[7:0]} : {56'd0, value[7:0]};
            2'd1: v = is_signed ? {{48{value[15]}}, value[15:0]} : {48'd0, value[15:0]};
            2'd2: v = is_signed ? {{32{value[31]}}, value[31:0]} : {32'd0, value[31:0]};
            default: v = value;
        endcase
        neg = is_signed & v[63];
        hex = (radix_sel != RADIX_OCT) && (radix_sel != RADIX_DEC);
        job.mag = neg ? (64'd0 - v) : v;
        job.radix = radix_sel;
        job.lower = lower_case;
        job.left = left_justify;
        job.zp = zero_pad & ~left_justify;
        if (neg)
            job.sign_ch = 8'h2d;
        else if (is_signed && show_plus)
            job.sign_ch = 8'h2b;
        else if (is_signed && show_space)
            job.sign_ch = 8'h20;
        else
            job.sign_ch = 8'h00;
        job.pfx0 = alt_prefix && (hex || ((radix_sel == RADIX_OCT) && (v != 64'd0)));
        job.pfxx = alt_prefix && hex;
        job.width = min_width;
        job.prec = min_digits;
    end
endmodule
`default_nettype wire

// File: sv/iff_queue.sv
// Two-entry job queue between front and back
`default_nettype none
module iff_queue
    import iff_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      din,
    input  wire logic pop,
    output job_t      dout,
    output logic      empty,
    output logic      full
);
    job_t mem_reg [QDEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wp_next = wp_reg ^ push;
        rp_next = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign dout = mem_reg[rp_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full = (cnt_reg == 2'd2);
endmodule
`default_nettype wire

// File: sv/iff_back.sv
// Back end: digit conversion, then character emission
`default_nettype none
module iff_back
    import iff_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    input  job_t            q_job,
    output logic            pop,
    output logic            strobe,
    output logic [7:0]      ch,
    output logic            last
);
    bs_t state_reg, state_next;
    job_t job_reg;
    logic [63:0] v_reg, v_next;
    logic [63:0] est_reg, est_next;
    logic [1:0] dph_reg, dph_next;
    logic [3:0] dig_mem [DIGIT_SLOTS];
    logic [4:0] n_reg, n_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [5:0] w_reg;
    logic [5:0] pz_reg;
    logic [5:0] sent_reg, sent_next;
    logic [4:0] rd_reg, rd_next;
    logic [3:0] dv_reg;
    logic [63:0] q;
    logic [63:0] prod;
    logic [63:0] diff;
    logic [3:0] rem;
    logic       dstep;
    logic       dig_we;
    logic [5:0] p;
    logic [7:0] w_tot;
    logic       em;
    logic [7:0] c;
    logic       end_item;
    logic       pad_sp;
    logic       pad_zero;
    logic       dig_left;
    logic       pad_right;
    logic [7:0] total;

    // divide by base: shifts for 8 and 16; for 10 a reciprocal estimate in a low and a high
    // step, then multiply back and correct by one
    always_comb
    begin
        q = v_reg;
        rem = 4'd0;
        prod = 64'd0;
        diff = 64'd0;
        est_next = est_reg;
        dstep = 1'b1;
        case (job_reg.radix)
            RADIX_OCT:
            begin
                q = v_reg >> 3;
                rem = {1'b0, v_reg[2:0]};
            end
            RADIX_DEC:
            begin
                case (dph_reg)
                    DPH_LO:
                    begin
                        dstep = 1'b0;
                        est_next = (v_reg >> 1) + (v_reg >> 2);
                        est_next = est_next + (est_next >> 4);
                    end
                    DPH_HI:
                    begin
                        dstep = 1'b0;
                        est_next = est_reg + (est_reg >> 8);
                        est_next = est_next + (est_next >> 16);
                        est_next = est_next + (est_next >> 32);
                    end
                    default:
                    begin
                        q = est_reg >> 3;
                        prod = (q << 3) + (q << 1);
                        diff = v_reg - prod;
                        if (diff > 64'd9)
                        begin
                            q = q + 64'd1;
                            rem = 4'(diff - 64'd10);
                        end
                        else
                            rem = 4'(diff);
                    end
                endcase
            end
            default:
            begin
                q = v_reg >> 4;
                rem = v_reg[3:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
            dig_mem[n_reg] <= rem;
        dv_reg <= dig_mem[rd_next];
    end

    always_comb
    begin
        p = (job_reg.prec > {1'b0, n_next}) ? job_reg.prec : {1'b0, n_next};
        w_tot = {2'd0, job_reg.width} - {7'd0, (job_reg.sign_ch != 8'h00)}
              - {7'd0, job_reg.pfx0} - {7'd0, job_reg.pfxx} - {2'd0, p};
    end

    assign pad_sp = !job_reg.left && !job_reg.zp && (cnt_reg < w_reg);
    assign pad_zero = (cnt_reg < pz_reg);
    assign dig_left = (rd_reg != 5'h1f) && (cnt_reg == 6'd0);
    assign pad_right = job_reg.left && ((cnt_reg - 6'd1) < w_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        v_next = v_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        rd_next = rd_reg;
        dph_next = dph_reg;
        case (state_reg)
            BS_IDLE:
            begin
                dph_next = DPH_LO;
                if (!q_empty)
                begin
                    v_next = q_job.mag;
                    n_next = 5'd0;
                    state_next = BS_CONV;
                end
            end
            BS_CONV:
            begin
                if (dstep)
                begin
                    v_next = q;
                    n_next = n_reg + 5'd1;
                    dph_next = DPH_LO;
                    if ((q == 64'd0) || (n_reg == 5'(DIGIT_SLOTS - 1)))
                    begin
                        state_next = BS_PADL;
                        cnt_next = 6'd0;
                    end
                end
                else
                    dph_next = dph_reg + 2'd1;
            end
            BS_PADL:
            begin
                rd_next = n_reg - 5'd1;
                if (pad_sp)
                    cnt_next = cnt_reg + 6'd1;
                else
                    state_next = BS_SIGN;
            end
            BS_SIGN: state_next = BS_PFX0;
            BS_PFX0: state_next = BS_PFXX;
            BS_PFXX:
            begin
                state_next = BS_ZERO;
                cnt_next = 6'd0;
            end
            BS_ZERO:
            begin
                if (pad_zero)
                    cnt_next = cnt_reg + 6'd1;
                else
                begin
                    state_next = BS_DIGS;
                    cnt_next = 6'd0;
                end
            end
            BS_DIGS:
            begin
                if (dig_left)
                begin
                    if (rd_reg == 5'd0)
                        cnt_next = 6'd1;
                    else
                        rd_next = rd_reg - 5'd1;
                end
                else if (pad_right)
                    cnt_next = cnt_reg + 6'd1;
                else
                    state_next = BS_IDLE;
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop = 1'b0;
        dig_we = 1'b0;
        em = 1'b0;
        c = 8'h20;
        case (state_reg)
            BS_IDLE: pop = !q_empty;
            BS_CONV: dig_we = dstep;
            BS_PADL: em = pad_sp;
            BS_SIGN:
            begin
                em = (job_reg.sign_ch != 8'h00);
                c = job_reg.sign_ch;
            end
            BS_PFX0:
            begin
                em = job_reg.pfx0;
                c = 8'h30;
            end
            BS_PFXX:
            begin
                em = job_reg.pfxx;
                c = job_reg.lower ? 8'h78 : 8'h58;
            end
            BS_ZERO:
            begin
                em = pad_zero;
                c = 8'h30;
            end
            BS_DIGS:
            begin
                if (dig_left)
                begin
                    em = 1'b1;
                    c = digit_char(dv_reg, job_reg.lower);
                end
                else
                    em = pad_right;
            end
            default: em = 1'b0;
        endcase
    end

    // total-length bookkeeping: last marks final char or the MAX_FIELD cut
    always_comb
    begin
        sent_next = sent_reg;
        end_item = 1'b0;
        if (state_reg == BS_IDLE)
            sent_next = 6'd0;
        else if (em)
            sent_next = sent_reg + 6'd1;
        if (em && (sent_reg == 6'(MAX_FIELD - 1)))
            end_item = 1'b1;
    end

    // lookahead for last: total = space pad + sign + pfx + zeros + n (zeros hold zero pad)
    always_comb
    begin
        total = {2'd0, (job_reg.zp ? 6'd0 : w_reg)} + {7'd0, (job_reg.sign_ch != 8'h00)}
              + {7'd0, job_reg.pfx0} + {7'd0, job_reg.pfxx} + {2'd0, pz_reg}
              + {3'd0, n_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        v_reg <= v_next;
        est_reg <= est_next;
        rd_reg <= rd_next;
        if (state_reg == BS_CONV && state_next == BS_PADL)
        begin
            w_reg <= w_tot[7] ? 6'd0 : w_tot[5:0];
            pz_reg <= ((job_reg.prec > {1'b0, n_next}) ? (job_reg.prec - {1'b0, n_next}) : 6'd0);
        end
        else if (state_reg == BS_PADL && state_next == BS_SIGN && job_reg.zp)
            pz_reg <= pz_reg + w_reg;
        ch <= c;
        last <= em && (end_item || ({2'd0, sent_reg} == total - 8'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            n_reg <= 5'd0;
            cnt_reg <= 6'd0;
            sent_reg <= 6'd0;
            dph_reg <= DPH_LO;
            strobe <= 1'b0;
        end
        else
        begin
            state_reg <= (em && end_item) ? BS_IDLE : state_next;
            n_reg <= n_next;
            cnt_reg <= cnt_next;
            sent_reg <= sent_next;
            dph_reg <= dph_next;
            strobe <= em;
        end
    end
endmodule
`default_nettype wire

// File: sv/iff_checker.sv
// Port-level checker for the integer field formatter, bound to the top level
`default_nettype none
`include "integer_field_formatter_core_assert.svh"
module iff_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic strobe,
    input wire logic last
);
    `IFF_ASSERT_IMP(a_last_strobe, last, strobe)
    `IFF_ASSERT_NXT(a_no_last_repeat, strobe && last, !(strobe && last))
    `IFF_ASSERT_IMP(a_hs_known, 1'b1, !$isunknown({start, busy}))
endmodule
bind integer_field_formatter_core iff_checker u_iff_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe), .last(last)
);
`default_nettype wire
